>>> sv/raf_pkg.sv
// Shared types, constants and helpers for the radix ASCII formatter.
package raf_pkg;

  localparam int DATA_W      = 64;
  localparam int RADIX_W     = 6;
  localparam int WIDTH_W     = 7;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_STORE = 64;
  localparam int ADDR_W      = $clog2(DIGIT_STORE);
  localparam int CHUNK_BITS  = 8;
  localparam int STEPS       = DATA_W / CHUNK_BITS;
  localparam int STEP_W      = $clog2(STEPS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SHIFT_W     = 3;

  localparam logic [RADIX_W-1:0] RADIX_MIN      = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX      = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_OCT      = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_HEX      = 6'd16;
  localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = 6'd10;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX      = 7'd64;
  localparam logic [WIDTH_W-1:0] HEX_PFX_LEN    = 7'd2;
  localparam logic [WIDTH_W-1:0] OCT_PFX_LEN    = 7'd1;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_HEX,
    PFX_OCT
  } prefix_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_SETUP,
    BK_PREFIX_A,
    BK_PREFIX_B,
    BK_PAD,
    BK_DIGITS
  } back_state_t;

  typedef struct packed {
    logic [DATA_W-1:0]  value;
    logic [RADIX_W-1:0] radix;
    logic [WIDTH_W-1:0] width;
    logic [CHAR_W-1:0]  pad;
    prefix_t            prefix;
    logic               pow2;
    logic [SHIFT_W-1:0] shift;
  } desc_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DECIMAL_DIGITS) c = CHAR_ZERO + CHAR_W'(d);
    else c = CHAR_A + CHAR_W'(d - DECIMAL_DIGITS);
    return c;
  endfunction

endpackage

>>> sv/rf_front.sv
// Front end: accepts a transaction, clamps fields and works out prefix and width.
module rf_front import raf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [DATA_W-1:0]  value,
  input  logic [RADIX_W-1:0] radix,
  input  logic [WIDTH_W-1:0] field_width,
  input  logic [CHAR_W-1:0]  pad_char,
  input  q_stat_t            q_stat,
  output logic               push,
  output desc_t              push_desc
);

  logic  held;
  desc_t desc;
  desc_t desc_next;

  assign push       = held && !q_stat.full;
  assign item_ready = !held || !q_stat.full;
  assign push_desc  = desc;

  always_comb begin
    desc_next.value  = value;
    desc_next.pad    = pad_char;
    desc_next.radix  = radix;
    if (radix < RADIX_MIN) desc_next.radix = RADIX_MIN;
    else if (radix > RADIX_MAX) desc_next.radix = RADIX_MAX;
    desc_next.width  = field_width;
    if (field_width > WIDTH_MAX) desc_next.width = WIDTH_MAX;
    desc_next.prefix = PFX_NONE;
    if (pad_char != CHAR_SPACE) begin
      if (desc_next.radix == RADIX_HEX) begin
        if (desc_next.width == '0 || desc_next.width > HEX_PFX_LEN) begin
          desc_next.prefix = PFX_HEX;
          if (desc_next.width != '0) desc_next.width = desc_next.width - HEX_PFX_LEN;
        end
      end else if (desc_next.radix == RADIX_OCT) begin
        desc_next.prefix = PFX_OCT;
        if (desc_next.width != '0) desc_next.width = desc_next.width - OCT_PFX_LEN;
      end
    end
    case (desc_next.radix)
      6'd2: begin
        desc_next.pow2  = 1'b1;
        desc_next.shift = 3'd1;
      end
      6'd4: begin
        desc_next.pow2  = 1'b1;
        desc_next.shift = 3'd2;
      end
      6'd8: begin
        desc_next.pow2  = 1'b1;
        desc_next.shift = 3'd3;
      end
      6'd16: begin
        desc_next.pow2  = 1'b1;
        desc_next.shift = 3'd4;
      end
      6'd32: begin
        desc_next.pow2  = 1'b1;
        desc_next.shift = 3'd5;
      end
      default: begin
        desc_next.pow2  = 1'b0;
        desc_next.shift = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item_ready) begin
      held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      desc <= desc_next;
    end
  end

endmodule

>>> sv/rf_queue.sv
// Short descriptor queue between the front end and the conversion engine.
module rf_queue import raf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  desc_t   push_desc,
  input  logic    pop,
  output q_stat_t q_stat,
  output desc_t   q_desc
);

  desc_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_stat.valid = count != '0;
  assign q_stat.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign q_desc       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

endmodule

>>> sv/rf_back.sv
// Conversion engine: digit generation into the digit store, then character output.
module rf_back import raf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  q_stat_t           q_stat,
  input  desc_t             q_desc,
  output logic              pop,
  output logic              busy,
  output logic              char_valid,
  input  logic              char_ready,
  output logic [CHAR_W-1:0] character,
  output logic              last
);

  back_state_t        state;
  back_state_t        state_next;
  desc_t              job;
  logic [DATA_W-1:0]  work;
  logic [DATA_W-1:0]  work_next;
  logic [RADIX_W-1:0] rem;
  logic [RADIX_W-1:0] rem_next;
  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_next;
  logic [WIDTH_W-1:0] nd;
  logic [WIDTH_W-1:0] nd_next;
  logic [WIDTH_W-1:0] nd_inc;
  logic [WIDTH_W-1:0] padcnt;
  logic [WIDTH_W-1:0] padcnt_next;
  logic [WIDTH_W-1:0] keep;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  rd_addr_next;
  logic [RADIX_W-1:0] rd_data;
  logic [RADIX_W-1:0] store [DIGIT_STORE];

  logic               dig_we;
  logic [RADIX_W-1:0] dig_data;
  logic               emit;
  logic               load;
  logic [CHAR_W-1:0]  load_char;
  logic               load_last;

  logic [RADIX_W:0]     t_acc;
  logic [RADIX_W-1:0]   t_rem;
  logic [CHUNK_BITS-1:0] qbits;
  logic [DATA_W-1:0]    chunk_work;
  logic [RADIX_W-1:0]   pow_mask;
  logic [RADIX_W-1:0]   pow_digit;
  logic [DATA_W-1:0]    pow_work;

  assign busy   = state != BK_IDLE;
  assign emit   = !char_valid || char_ready;
  assign nd_inc = nd + 1'b1;

  // one quotient chunk of restoring long division per cycle
  always_comb begin
    t_rem = rem;
    t_acc = '0;
    qbits = '0;
    for (int i = 0; i < CHUNK_BITS; i++) begin
      t_acc = {t_rem, work[DATA_W-1-i]};
      if (t_acc >= {1'b0, job.radix}) begin
        t_acc = t_acc - {1'b0, job.radix};
        qbits[CHUNK_BITS-1-i] = 1'b1;
      end
      t_rem = t_acc[RADIX_W-1:0];
    end
    chunk_work = {work[DATA_W-CHUNK_BITS-1:0], qbits};
    pow_mask   = (RADIX_W'(1) << job.shift) - 1'b1;
    pow_digit  = work[RADIX_W-1:0] & pow_mask;
    pow_work   = work >> job.shift;
  end

  always_comb begin
    state_next   = state;
    work_next    = work;
    rem_next     = rem;
    step_next    = step;
    nd_next      = nd;
    padcnt_next  = padcnt;
    rd_addr_next = rd_addr;
    keep         = nd;
    pop          = 1'b0;
    dig_we       = 1'b0;
    dig_data     = t_rem;
    load         = 1'b0;
    load_char    = job.pad;
    load_last    = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_stat.valid) begin
          pop        = 1'b1;
          work_next  = q_desc.value;
          rem_next   = '0;
          step_next  = '0;
          nd_next    = '0;
          state_next = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (job.pow2) begin
          dig_we    = 1'b1;
          dig_data  = pow_digit;
          work_next = pow_work;
          nd_next   = nd_inc;
          if (pow_work == '0 || nd_inc == WIDTH_W'(DIGIT_STORE)) state_next = BK_SETUP;
        end else begin
          work_next = chunk_work;
          rem_next  = t_rem;
          step_next = step + 1'b1;
          if (step == STEP_W'(STEPS - 1)) begin
            dig_we   = 1'b1;
            nd_next  = nd_inc;
            rem_next = '0;
            if (chunk_work == '0 || nd_inc == WIDTH_W'(DIGIT_STORE)) state_next = BK_SETUP;
          end
        end
      end
      BK_SETUP: begin
        if (job.width != '0 && job.width <= nd) keep = job.width;
        padcnt_next  = (job.width > nd) ? job.width - nd : '0;
        rd_addr_next = ADDR_W'(keep - 1'b1);
        if (job.prefix != PFX_NONE) state_next = BK_PREFIX_A;
        else if (job.width > nd) state_next = BK_PAD;
        else state_next = BK_DIGITS;
      end
      BK_PREFIX_A: begin
        load_char = (job.prefix == PFX_HEX) ? CHAR_ZERO : job.pad;
        if (emit) begin
          load = 1'b1;
          if (job.prefix == PFX_HEX) state_next = BK_PREFIX_B;
          else if (padcnt != '0) state_next = BK_PAD;
          else state_next = BK_DIGITS;
        end
      end
      BK_PREFIX_B: begin
        load_char = CHAR_X;
        if (emit) begin
          load = 1'b1;
          if (padcnt != '0) state_next = BK_PAD;
          else state_next = BK_DIGITS;
        end
      end
      BK_PAD: begin
        load_char = job.pad;
        if (emit) begin
          load        = 1'b1;
          padcnt_next = padcnt - 1'b1;
          if (padcnt == WIDTH_W'(1)) state_next = BK_DIGITS;
        end
      end
      BK_DIGITS: begin
        load_char = digit_char(rd_data);
        load_last = rd_addr == '0;
        if (emit) begin
          load         = 1'b1;
          rd_addr_next = rd_addr - 1'b1;
          if (rd_addr == '0) state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      char_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) char_valid <= 1'b1;
      else if (char_ready) char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job <= q_desc;
    work    <= work_next;
    rem     <= rem_next;
    step    <= step_next;
    nd      <= nd_next;
    padcnt  <= padcnt_next;
    rd_addr <= rd_addr_next;
    if (load) begin
      character <= load_char;
      last      <= load_last;
    end
  end

  // digit store, least significant digit at address 0
  always_ff @(posedge clk) begin
    if (dig_we) store[nd[ADDR_W-1:0]] <= dig_data;
    rd_data <= store[rd_addr_next];
  end

endmodule

>>> sv/radix_ascii_formatter.sv
// Top level: 64-bit value to ASCII in radix 2..36, one character per output handshake.
// After acceptance the first character passes the front-end register, the queue, digit
//   generation, setup and the output register. A power-of-two radix yields digits by shifting,
//   else by division at eight quotient bits per cycle through one compare-subtract chain.
// Engine: one conversion at a time; further accepted transactions wait in the queue.
// Reset: synchronous, clears handshake and sequencing state; digit store is not cleared.
module radix_ascii_formatter import raf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [DATA_W-1:0]  value,
  input  logic [RADIX_W-1:0] radix,
  input  logic [WIDTH_W-1:0] field_width,
  input  logic [CHAR_W-1:0]  pad_char,
  output logic               char_valid,
  input  logic               char_ready,
  output logic [CHAR_W-1:0]  character,
  output logic               last
);

  q_stat_t q_stat;
  desc_t   push_desc;
  desc_t   q_desc;
  logic    q_push;
  logic    q_pop;
  logic    busy;

  rf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .value       (value),
    .radix       (radix),
    .field_width (field_width),
    .pad_char    (pad_char),
    .q_stat      (q_stat),
    .push        (q_push),
    .push_desc   (push_desc)
  );

  rf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .q_stat    (q_stat),
    .q_desc    (q_desc)
  );

  rf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .q_desc     (q_desc),
    .pop        (q_pop),
    .busy       (busy),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .character  (character),
    .last       (last)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  a_start_queued: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(q_stat.valid))
    else $error("engine started without a queued transaction");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !char_valid && !busy)
    else $error("output or engine active after reset");

endmodule

>>> bench/raf_char_checker.sv
// Checker for the radix ASCII formatter: predicts the character stream and compares it.
module raf_char_checker import raf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  logic [DATA_W-1:0]  value,
  input  logic [RADIX_W-1:0] radix,
  input  logic [WIDTH_W-1:0] field_width,
  input  logic [CHAR_W-1:0]  pad_char,
  input  logic               char_valid,
  input  logic               char_ready,
  input  logic [CHAR_W-1:0]  character,
  input  logic               last,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } out_char_t;

  out_char_t expected_chars[$];
  int        fail_tally   = 0;
  int        pending_char = 0;

  assign mismatches  = fail_tally;
  assign outstanding = pending_char;

  function automatic void queue_conversion(logic [DATA_W-1:0] num, logic [RADIX_W-1:0] rdx,
                                           logic [WIDTH_W-1:0] wid, logic [CHAR_W-1:0] fill);
    logic [RADIX_W-1:0] base;
    logic [DATA_W-1:0]  rem;
    int                 w;
    int                 keep;
    int                 pad;
    logic [CHAR_W-1:0]  line[$];
    logic [CHAR_W-1:0]  lsd_first[$];
    out_char_t          oc;
    base = rdx;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    w = int'(wid);
    if (w > int'(WIDTH_MAX)) w = int'(WIDTH_MAX);
    if (fill != CHAR_SPACE) begin
      if (base == RADIX_HEX) begin
        if (w == 0 || w > 2) begin
          line.push_back(CHAR_ZERO);
          line.push_back(CHAR_X);
          if (w != 0) w -= 2;
        end
      end else if (base == RADIX_OCT) begin
        line.push_back(fill);
        if (w != 0) w -= 1;
      end
    end
    do begin
      rem = num % base;
      if (rem < 10) lsd_first.push_back(CHAR_ZERO + rem[CHAR_W-1:0]);
      else lsd_first.push_back(CHAR_A + rem[CHAR_W-1:0] - 8'd10);
      num = num / base;
    end while (num != 0 && lsd_first.size() < DIGIT_STORE);
    keep = lsd_first.size();
    if (w != 0) begin
      if (w > keep) begin
        pad = w - keep;
        while (pad > 0 && line.size() < 64) begin
          line.push_back(fill);
          pad--;
        end
      end else begin
        keep = w;
      end
    end
    for (int k = keep; k > 0 && line.size() < 64; k--) line.push_back(lsd_first[k-1]);
    foreach (line[i]) begin
      oc.ch  = line[i];
      oc.fin = (i == line.size() - 1);
      expected_chars.push_back(oc);
    end
  endfunction

  always @(posedge clk) begin
    out_char_t e;
    if (!rst) begin
      if (char_valid && char_ready) begin
        if (expected_chars.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10)
            $display("%0t: unexpected character %h last %b", $realtime, character, last);
        end else begin
          e = expected_chars.pop_front();
          if (e.ch !== character || e.fin !== last) begin
            fail_tally++;
            if (fail_tally <= 10)
              $display("%0t: character expected %h got %h, last expected %b got %b",
                       $realtime, e.ch, character, e.fin, last);
          end
        end
      end
      if (item_valid && item_ready) queue_conversion(value, radix, field_width, pad_char);
      pending_char = expected_chars.size();
    end
  end

endmodule

>>> bench/tb_top.sv
// Top of the radix ASCII formatter bench: clock, reset, stimulus and verdict.
module tb_top import raf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 84;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic [DATA_W-1:0]  value = '0;
  logic [RADIX_W-1:0] radix = RADIX_MIN;
  logic [WIDTH_W-1:0] field_width = '0;
  logic [CHAR_W-1:0]  pad_char = CHAR_SPACE;
  logic               char_valid;
  logic               char_ready = 1'b0;
  logic [CHAR_W-1:0]  character;
  logic               last;

  int   mismatches;
  int   outstanding;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   cycles = 0;
  logic item_taken = 1'b0;

  radix_ascii_formatter DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .value(value), .radix(radix), .field_width(field_width), .pad_char(pad_char),
    .char_valid(char_valid), .char_ready(char_ready),
    .character(character), .last(last)
  );

  raf_char_checker checker_i (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .value(value), .radix(radix), .field_width(field_width), .pad_char(pad_char),
    .char_valid(char_valid), .char_ready(char_ready),
    .character(character), .last(last),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    item_taken <= !rst && item_valid && item_ready;
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) char_ready <= !rst && ($urandom_range(0, 99) >= rx_idle_pct);

  task automatic send_conversion(logic [DATA_W-1:0] v, logic [RADIX_W-1:0] r,
                                 logic [WIDTH_W-1:0] w, logic [CHAR_W-1:0] p);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid  <= 1'b1;
    value       <= v;
    radix       <= r;
    field_width <= w;
    pad_char    <= p;
    do @(negedge clk); while (!item_taken);
  endtask

  task automatic drain_output();
    item_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic send_random_conversion();
    logic [DATA_W-1:0]  v;
    logic [RADIX_W-1:0] r;
    logic [WIDTH_W-1:0] w;
    logic [CHAR_W-1:0]  p;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    case ($urandom_range(0, 9))
      0: r = RADIX_MIN;
      1: r = RADIX_OCT;
      2: r = RADIX_HEX;
      3: r = 6'd10;
      4: r = RADIX_MAX;
      5: r = RADIX_W'($urandom_range(0, 63));
      default: r = RADIX_W'($urandom_range(2, 36));
    endcase
    case ($urandom_range(0, 5))
      0: w = '0;
      1: w = WIDTH_W'($urandom_range(1, 3));
      2: w = WIDTH_W'($urandom_range(65, 127));
      3: w = WIDTH_W'($urandom_range(0, 127));
      default: w = WIDTH_W'($urandom_range(0, 24));
    endcase
    case ($urandom_range(0, 3))
      0: p = CHAR_SPACE;
      1: p = CHAR_ZERO;
      default: p = CHAR_W'($urandom_range(0, 255));
    endcase
    send_conversion(v, r, w, p);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tx_idle_pct = 32;
    rx_idle_pct = 57;
    send_conversion('0, 6'd10, 7'd0, CHAR_SPACE);
    send_conversion('1, RADIX_MIN, 7'd0, CHAR_ZERO);
    send_conversion('1, RADIX_MAX, 7'd0, CHAR_SPACE);
    send_conversion('1, RADIX_HEX, 7'd0, CHAR_ZERO);
    send_conversion(64'h1234, RADIX_HEX, 7'd1, CHAR_ZERO);
    send_conversion(64'hAB, RADIX_HEX, 7'd2, 8'h2A);
    send_conversion(64'hFF, RADIX_HEX, 7'd3, CHAR_ZERO);
    send_conversion(64'hFF, RADIX_HEX, 7'd10, CHAR_SPACE);
    send_conversion(64'd8, RADIX_OCT, 7'd1, CHAR_ZERO);
    send_conversion(64'd511, RADIX_OCT, 7'd0, CHAR_ZERO);
    send_conversion(64'd511, RADIX_OCT, 7'd8, 8'hFF);
    send_conversion(64'd5, 6'd0, 7'd0, CHAR_SPACE);
    send_conversion(64'd5, 6'd1, 7'd6, CHAR_ZERO);
    send_conversion(64'd1295, 6'd37, 7'd0, CHAR_SPACE);
    send_conversion('1, 6'd63, 7'd0, 8'h2E);
    send_conversion(64'd99, 6'd10, WIDTH_MAX, CHAR_ZERO);
    send_conversion(64'd99, 6'd10, 7'd65, 8'h2E);
    send_conversion(64'd99, 6'd7, 7'd127, 8'h00);
    send_conversion(64'd12345, 6'd10, 7'd3, CHAR_SPACE);
    send_conversion(64'h8000_0000_0000_0000, RADIX_MIN, WIDTH_MAX, CHAR_ZERO);
    send_conversion('1, RADIX_HEX, WIDTH_MAX, 8'h55);
    send_conversion('0, RADIX_OCT, 7'd0, CHAR_ZERO);
    send_conversion('0, RADIX_HEX, 7'd2, CHAR_ZERO);
    drain_output();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 32; rx_idle_pct = 57; end
        1: begin tx_idle_pct = 57; rx_idle_pct = 32; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int i = 0; i < RANDOM_ITEMS; i++) send_random_conversion();
      drain_output();
    end

    repeat (100) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
sv/raf_pkg.sv
sv/rf_front.sv
sv/rf_queue.sv
sv/rf_back.sv
sv/radix_ascii_formatter.sv
bench/raf_char_checker.sv
bench/tb_top.sv
